// File: sv/srclex_pkg.sv
// ----------------------------------------------------------------------------
// srclex_pkg
// Shared types, constants and classification helpers for the source lexer.
// ----------------------------------------------------------------------------
package srclex_pkg;

    localparam int POSITION_BITS = 20;
    localparam int KEYWORD_MAX_CHARS = 6;
    localparam int WIN_BITS = KEYWORD_MAX_CHARS * 8;
    localparam int LEN_BITS = POSITION_BITS + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [LEN_BITS-1:0] len_t;
    typedef logic [4:0] kind_t;

    localparam kind_t KIND_IDENT  = 5'd0;
    localparam kind_t KIND_NUMBER = 5'd1;
    localparam kind_t KIND_STRING = 5'd2;
    localparam kind_t KIND_VAR    = 5'd3;
    localparam kind_t KIND_IF     = 5'd4;
    localparam kind_t KIND_FN     = 5'd5;
    localparam kind_t KIND_RETURN = 5'd6;
    localparam kind_t KIND_LE     = 5'd17;
    localparam kind_t KIND_GE     = 5'd19;
    localparam kind_t KIND_EQEQ   = 5'd20;
    localparam kind_t KIND_END    = 5'd22;
    localparam kind_t KIND_NONE   = 5'd0;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b0000001,
        MODE_COMMENT  = 7'b0000010,
        MODE_STRING   = 7'b0000100,
        MODE_NUM_INT  = 7'b0001000,
        MODE_NUM_FRAC = 7'b0010000,
        MODE_IDENT    = 7'b0100000,
        MODE_OPER     = 7'b1000000
    } mode_t;

    // one token as it travels from the scanner to the output stage
    typedef struct packed {
        kind_t kind;
        pos_t  start;
        len_t  len;
        pos_t  line;
        pos_t  col;
        logic  last;
    } token_t;

    // up to three tokens produced by one byte
    typedef struct packed {
        logic [2:0] vld;
        token_t [2:0] tok;
    } bundle_t;

    function automatic pos_t sat_inc(input pos_t v);
        sat_inc = (v == POS_MAX) ? v : v + pos_t'(1);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic kind_t single_op(input logic [7:0] c);
        unique case (c)
            8'h28:   single_op = 5'd7;
            8'h29:   single_op = 5'd8;
            8'h7B:   single_op = 5'd9;
            8'h7D:   single_op = 5'd10;
            8'h2B:   single_op = 5'd11;
            8'h2D:   single_op = 5'd12;
            8'h2A:   single_op = 5'd13;
            8'h2F:   single_op = 5'd14;
            8'h3A:   single_op = 5'd15;
            8'h3C:   single_op = 5'd16;
            8'h3E:   single_op = 5'd18;
            8'h3D:   single_op = 5'd21;
            default: single_op = KIND_NONE;
        endcase
    endfunction

endpackage

// File: sv/source_lexer_core.sv
// ----------------------------------------------------------------------------
// source_lexer_core
// Streaming tokenizer: one source byte in, up to three tokens out.
// ----------------------------------------------------------------------------
// A finished token is registered in the bundle queue before it is offered.
// Throughput: one byte per cycle while the queue has room, out_ready is high
// and each byte yields at most one token; a byte's tokens leave one at a time.
// Reset: rst_n clears scan state, positions and the bundle queue at once.
module source_lexer_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               char_in,
    input  logic                     is_last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [4:0]               token_kind,
    output logic [19:0]              start_offset,
    output logic [20:0]              text_length,
    output logic [19:0]              line_number,
    output logic [19:0]              column_number,
    output logic                     run_last
);
    import srclex_pkg::*;

    bundle_t s_bnd, q_bnd;
    logic s_valid, s_ready, q_valid, q_ready;
    token_t t;

    srclex_scan u_scan (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_in(char_in), .is_last(is_last),
        .bnd_valid(s_valid), .bnd_ready(s_ready), .bnd(s_bnd)
    );

    srclex_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(s_bnd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_bnd)
    );

    srclex_emit u_emit (
        .clk(clk), .rst_n(rst_n),
        .bnd_valid(q_valid), .bnd_ready(q_ready), .bnd(q_bnd),
        .out_valid(out_valid), .out_ready(out_ready), .tok(t)
    );

    assign token_kind    = t.kind;
    assign start_offset  = t.start;
    assign text_length   = t.len;
    assign line_number   = t.line;
    assign column_number = t.col;
    assign run_last      = t.last;

endmodule

// File: sv/srclex_scan.sv
// ----------------------------------------------------------------------------
// srclex_scan
// Front end: accepts one byte per cycle while bnd_ready is high, tracks scan
// mode and positions, and produces the bundle of tokens that the byte finishes.
// ----------------------------------------------------------------------------
module srclex_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_in,
    input  logic                is_last,
    output logic                bnd_valid,
    input  logic                bnd_ready,
    output srclex_pkg::bundle_t bnd
);
    import srclex_pkg::*;

    mode_t mode_reg, mode_next;
    logic  dq_reg, dq_next;
    logic [7:0] pend_reg, pend_next;
    logic [WIN_BITS-1:0] win_reg, win_next;
    pos_t tstart_reg, tstart_next, tline_reg, tline_next, tcol_reg, tcol_next;
    pos_t pos_reg, pos_next, line_reg, line_next, col_reg, col_next;
    len_t tlen_reg, tlen_next;

    logic [2:0] vld;
    token_t [2:0] tok;
    logic  take, newline, do_fresh, do_flush;
    pos_t  p;
    len_t  span_p, span_p1;
    kind_t ident_k;
    logic [7:0] c;

    assign in_ready = bnd_ready;
    assign take     = in_valid & in_ready;
    assign bnd_valid = in_valid;
    assign c = char_in;
    assign p = pos_reg;

    // token length runs alongside the byte position; clipped at the top
    assign span_p  = tlen_reg;
    assign span_p1 = (pos_reg == POS_MAX) ? tlen_reg : tlen_reg + len_t'(1);

    always_comb
    begin
        ident_k = KIND_IDENT;
        if (tlen_reg == len_t'(3) && win_reg[23:0] == 24'h766172) ident_k = KIND_VAR;
        if (tlen_reg == len_t'(2) && win_reg[15:0] == 16'h6966)   ident_k = KIND_IF;
        if (tlen_reg == len_t'(2) && win_reg[15:0] == 16'h666E)   ident_k = KIND_FN;
        if (tlen_reg == len_t'(6) && win_reg[47:0] == 48'h72657475726E)
            ident_k = KIND_RETURN;
    end

    function automatic token_t mk(input kind_t k, input pos_t s, input len_t l,
                                  input pos_t ln, input pos_t cl);
        token_t t;
        t.kind = k; t.start = s; t.len = l; t.line = ln; t.col = cl; t.last = 1'b0;
        mk = t;
    endfunction

    always_comb
    begin
        logic [1:0] n;
        mode_t fm;
        len_t lastlen;
        n = 2'd0;
        vld = '0;
        tok = '0;
        mode_next = mode_reg;
        dq_next = dq_reg;
        pend_next = pend_reg;
        win_next = win_reg;
        tstart_next = tstart_reg;
        tline_next = tline_reg;
        tcol_next = tcol_reg;
        tlen_next = span_p1;
        newline = 1'b0;
        do_fresh = 1'b0;
        do_flush = 1'b0;
        fm = MODE_IDLE;
        lastlen = '0;

        unique case (mode_reg)
            MODE_COMMENT:
                if (c == CH_NL)
                begin
                    newline = 1'b1;
                    mode_next = MODE_IDLE;
                end
            MODE_STRING:
                if (c == (dq_reg ? CH_DQ : CH_SQ))
                begin
                    vld[0] = 1'b1;
                    tok[0] = mk(KIND_STRING, tstart_reg, span_p, tline_reg, tcol_reg);
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                end
            MODE_NUM_INT:
                if (c == CH_DOT) mode_next = MODE_NUM_FRAC;
                else if (!is_digit(c)) do_flush = 1'b1;
            MODE_NUM_FRAC:
                if (!is_digit(c)) do_flush = 1'b1;
            MODE_IDENT:
                if (c == CH_UNDER || is_alpha(c) || is_digit(c))
                    win_next = {win_reg[WIN_BITS-9:0], c};
                else
                    do_flush = 1'b1;
            MODE_OPER:
                if (c == CH_EQ && (pend_reg == CH_LT || pend_reg == CH_GT
                                   || pend_reg == CH_EQ))
                begin
                    vld[0] = 1'b1;
                    tok[0] = mk(pend_reg == CH_LT ? KIND_LE :
                                pend_reg == CH_GT ? KIND_GE : KIND_EQEQ,
                                tstart_reg, len_t'(2), tline_reg, tcol_reg);
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                    do_flush = 1'b1;
            default:
                do_fresh = 1'b1;
        endcase

        if (do_flush)
        begin
            vld[0] = 1'b1;
            n = 2'd1;
            priority case (1'b1)
                mode_reg == MODE_IDENT:
                    tok[0] = mk(ident_k, tstart_reg, span_p, tline_reg, tcol_reg);
                mode_reg == MODE_OPER:
                    tok[0] = mk(single_op(pend_reg), tstart_reg, len_t'(1),
                                tline_reg, tcol_reg);
                default:
                    tok[0] = mk(KIND_NUMBER, tstart_reg, span_p, tline_reg, tcol_reg);
            endcase
            mode_next = MODE_IDLE;
            do_fresh = 1'b1;
        end

        if (do_fresh)
        begin
            fm = MODE_IDLE;
            tlen_next = len_t'(1);
            if (is_space(c))
                newline = (c == CH_NL);
            else if (c == CH_HASH)
                fm = MODE_COMMENT;
            else if (c == CH_SQ || c == CH_DQ)
            begin
                fm = MODE_STRING;
                dq_next = (c == CH_DQ);
                tstart_next = sat_inc(p);
                tline_next = line_reg;
                tcol_next = col_reg;
                tlen_next = '0;
            end
            else if (is_digit(c) || c == CH_DOT)
            begin
                fm = MODE_NUM_INT;
                tstart_next = p; tline_next = line_reg; tcol_next = col_reg;
            end
            else if (single_op(c) != KIND_NONE)
            begin
                tstart_next = p; tline_next = line_reg; tcol_next = col_reg;
                if (c == CH_LT || c == CH_GT || c == CH_EQ)
                begin
                    fm = MODE_OPER;
                    pend_next = c;
                end
                else
                begin
                    vld[n] = 1'b1;
                    tok[n] = mk(single_op(c), p, len_t'(1), line_reg, col_reg);
                    n = n + 2'd1;
                end
            end
            else if (c == CH_UNDER || is_alpha(c))
            begin
                fm = MODE_IDENT;
                win_next = WIN_BITS'(c);
                tstart_next = p; tline_next = line_reg; tcol_next = col_reg;
            end
            mode_next = fm;
        end

        pos_next = sat_inc(p);
        if (newline)
        begin
            line_next = sat_inc(line_reg);
            col_next = '0;
        end
        else
        begin
            line_next = line_reg;
            col_next = sat_inc(col_reg);
        end

        if (is_last)
        begin
            // the open token ends one past this byte, unclipped
            lastlen = len_t'(p) + len_t'(1) - len_t'(tstart_next);
            // flush the open token, then the end marker
            if (mode_next == MODE_IDENT || mode_next == MODE_NUM_INT
                || mode_next == MODE_NUM_FRAC || mode_next == MODE_STRING
                || mode_next == MODE_OPER)
            begin
                vld[n] = 1'b1;
                if (mode_next == MODE_OPER)
                    tok[n] = mk(single_op(pend_next), tstart_next, len_t'(1),
                                tline_next, tcol_next);
                else if (mode_next == MODE_STRING)
                    tok[n] = mk(KIND_STRING, tstart_next, lastlen,
                                tline_next, tcol_next);
                else if (mode_next == MODE_IDENT)
                begin
                    tok[n] = mk(KIND_IDENT, tstart_next, lastlen, tline_next, tcol_next);
                    if (lastlen == len_t'(3) && win_next[23:0] == 24'h766172)
                        tok[n].kind = KIND_VAR;
                    if (lastlen == len_t'(2) && win_next[15:0] == 16'h6966)
                        tok[n].kind = KIND_IF;
                    if (lastlen == len_t'(2) && win_next[15:0] == 16'h666E)
                        tok[n].kind = KIND_FN;
                    if (lastlen == len_t'(6) && win_next[47:0] == 48'h72657475726E)
                        tok[n].kind = KIND_RETURN;
                end
                else
                    tok[n] = mk(KIND_NUMBER, tstart_next, lastlen, tline_next, tcol_next);
                n = n + 2'd1;
            end
            vld[n] = 1'b1;
            tok[n] = mk(KIND_END, pos_next, '0, line_next, col_next);
            tok[n].last = 1'b1;
        end
        else if (n != 2'd0)
            tok[n - 2'd1].last = 1'b1;
    end

    assign bnd.vld = vld;
    assign bnd.tok = tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            dq_reg <= 1'b0;
            pend_reg <= '0;
            win_reg <= '0;
            tstart_reg <= '0;
            tline_reg <= '0;
            tcol_reg <= '0;
            tlen_reg <= '0;
            pos_reg <= '0;
            line_reg <= '0;
            col_reg <= '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                mode_reg <= MODE_IDLE;
                dq_reg <= 1'b0;
                pend_reg <= '0;
                win_reg <= '0;
                tstart_reg <= '0;
                tline_reg <= '0;
                tcol_reg <= '0;
                tlen_reg <= '0;
                pos_reg <= '0;
                line_reg <= '0;
                col_reg <= '0;
            end
            else
            begin
                mode_reg <= mode_next;
                dq_reg <= dq_next;
                pend_reg <= pend_next;
                win_reg <= win_next;
                tstart_reg <= tstart_next;
                tline_reg <= tline_next;
                tcol_reg <= tcol_next;
                tlen_reg <= tlen_next;
                pos_reg <= pos_next;
                line_reg <= line_next;
                col_reg <= col_next;
            end
        end
    end

endmodule

// File: sv/srclex_queue.sv
// ----------------------------------------------------------------------------
// srclex_queue
// Two-entry queue of token bundles between the scanner and the emitter.
// ----------------------------------------------------------------------------
module srclex_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  srclex_pkg::bundle_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output srclex_pkg::bundle_t rd_data
);
    import srclex_pkg::*;

    bundle_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    // drop bundles that carry no token
    assign wr = wr_valid & wr_ready & (wr_data.vld != 3'b000);
    assign rd = rd_valid & rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// File: sv/srclex_emit.sv
// ----------------------------------------------------------------------------
// srclex_emit
// Back end: walks the tokens of each bundle and presents them one at a time.
// ----------------------------------------------------------------------------
module srclex_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                bnd_valid,
    output logic                bnd_ready,
    input  srclex_pkg::bundle_t bnd,
    output logic                out_valid,
    input  logic                out_ready,
    output srclex_pkg::token_t  tok
);
    import srclex_pkg::*;

    logic [1:0] idx_reg;
    logic [2:0] vld;
    logic more;

    assign vld = bnd.vld;
    assign out_valid = bnd_valid;
    assign tok = bnd.tok[idx_reg];
    assign more = (idx_reg == 2'd0) ? vld[1] : (idx_reg == 2'd1) ? vld[2] : 1'b0;
    // release the bundle once its final token leaves
    assign bnd_ready = out_ready & ~more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (out_valid && out_ready)
            idx_reg <= more ? idx_reg + 2'd1 : 2'd0;
    end

endmodule

// File: sv/srclex_checker.sv
// ----------------------------------------------------------------------------
// srclex_checker
// Port-level checks on the lexer's output stream.
// ----------------------------------------------------------------------------
module srclex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  token_kind,
    input logic [20:0] text_length,
    input logic        run_last
);
    import srclex_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("output changed while stalled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> run_last && text_length == '0)
        else $error("end token malformed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= KIND_END)
        else $error("bad token kind");

endmodule

bind source_lexer_core srclex_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .text_length(text_length), .run_last(run_last)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream tokenizer check: directed table then random source text, with
// an in-bench scanner predicting every token and its position fields.
// ----------------------------------------------------------------------------
module tb;
    import srclex_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        SC_IDLE, SC_COMMENT, SC_STRING, SC_INT, SC_FRAC, SC_WORD, SC_OPER
    } scan_t;

    typedef struct packed {
        kind_t kind;
        pos_t  start;
        len_t  len;
        pos_t  line;
        pos_t  col;
        logic  last;
    } tok_exp_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        logic       has_exp;
        kind_t      kind;
        pos_t       start;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] char_in;
    logic is_last;
    logic out_valid;
    logic out_ready;
    logic [4:0] token_kind;
    logic [19:0] start_offset;
    logic [20:0] text_length;
    logic [19:0] line_number;
    logic [19:0] column_number;
    logic run_last;

    source_lexer_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_in(char_in), .is_last(is_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .start_offset(start_offset),
        .text_length(text_length), .line_number(line_number),
        .column_number(column_number), .run_last(run_last)
    );

    // predictor state
    scan_t          sc_mode;
    logic           sc_dq;
    logic [7:0]     sc_op;
    logic [WIN_BITS-1:0] sc_win;
    pos_t           sc_start, sc_line, sc_col;
    pos_t           cur_pos, cur_line, cur_col;

    tok_exp_t       token_queue[$];
    tok_exp_t       step_toks[$];
    int             errors;
    int             cycles;
    logic           done;

    function automatic pos_t inc_pos(pos_t v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic kind_t op_kind(logic [7:0] c);
        case (c)
            "(": return 5'd7;
            ")": return 5'd8;
            "{": return 5'd9;
            "}": return 5'd10;
            "+": return 5'd11;
            "-": return 5'd12;
            "*": return 5'd13;
            "/": return 5'd14;
            ":": return 5'd15;
            "<": return 5'd16;
            ">": return 5'd18;
            "=": return 5'd21;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c inside {"(", ")", "{", "}", "+", "-", "*", "/", ":", "<", ">", "="};
    endfunction

    function automatic logic digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic push_tok(kind_t k, logic [63:0] s, logic [63:0] l, pos_t ln, pos_t cl);
        tok_exp_t t;
        t.kind = k;
        t.start = s[19:0];
        t.len = l[20:0];
        t.line = ln;
        t.col = cl;
        t.last = 1'b0;
        step_toks.push_back(t);
    endtask

    function automatic logic [63:0] span_to(logic [63:0] end_excl);
        return (end_excl > sc_start) ? end_excl - sc_start : 64'd0;
    endfunction

    function automatic kind_t word_kind(logic [63:0] len);
        if (len == 3 && sc_win[23:0] == "var") return KIND_VAR;
        if (len == 2 && sc_win[15:0] == "if") return KIND_IF;
        if (len == 2 && sc_win[15:0] == "fn") return KIND_FN;
        if (len == 6 && sc_win[47:0] == "return") return KIND_RETURN;
        return KIND_IDENT;
    endfunction

    task automatic flush_pending(logic [63:0] end_excl);
        case (sc_mode)
            SC_INT, SC_FRAC:
                push_tok(KIND_NUMBER, sc_start, span_to(end_excl), sc_line, sc_col);
            SC_WORD:
                push_tok(word_kind(span_to(end_excl)), sc_start, span_to(end_excl),
                         sc_line, sc_col);
            SC_OPER:
                push_tok(op_kind(sc_op), sc_start, 1, sc_line, sc_col);
            SC_STRING:
                push_tok(KIND_STRING, sc_start, span_to(end_excl), sc_line, sc_col);
            default: ;
        endcase
        sc_mode = SC_IDLE;
    endtask

    task automatic begin_token(logic [7:0] c, output logic nl);
        nl = 1'b0;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) nl = (c == CH_NL);
        else if (c == CH_HASH) sc_mode = SC_COMMENT;
        else if (c == CH_SQ || c == CH_DQ)
        begin
            sc_mode = SC_STRING;
            sc_dq = (c == CH_DQ);
            sc_start = inc_pos(cur_pos);
            sc_line = cur_line;
            sc_col = cur_col;
        end
        else if (digit_ch(c) || c == CH_DOT)
        begin
            sc_mode = SC_INT;
            sc_start = cur_pos;
            sc_line = cur_line;
            sc_col = cur_col;
        end
        else if (is_op(c))
        begin
            sc_start = cur_pos;
            sc_line = cur_line;
            sc_col = cur_col;
            if (c == CH_LT || c == CH_GT || c == CH_EQ)
            begin
                sc_mode = SC_OPER;
                sc_op = c;
            end
            else push_tok(op_kind(c), cur_pos, 1, cur_line, cur_col);
        end
        else if (c == CH_UNDER || letter_ch(c))
        begin
            sc_mode = SC_WORD;
            sc_win = WIN_BITS'(c);
            sc_start = cur_pos;
            sc_line = cur_line;
            sc_col = cur_col;
        end
    endtask

    task automatic clear_scanner();
        sc_mode = SC_IDLE;
        sc_dq = 0;
        sc_op = 0;
        sc_win = 0;
        sc_start = 0;
        sc_line = 0;
        sc_col = 0;
        cur_pos = 0;
        cur_line = 0;
        cur_col = 0;
    endtask

    // advance the scanner by one byte and queue what it emits
    task automatic scan_byte(logic [7:0] c, logic fin);
        logic nl;
        kind_t pk;
        nl = 1'b0;
        step_toks.delete();
        case (sc_mode)
            SC_COMMENT:
                if (c == CH_NL)
                begin
                    nl = 1'b1;
                    sc_mode = SC_IDLE;
                end
            SC_STRING:
                if (c == (sc_dq ? CH_DQ : CH_SQ))
                begin
                    push_tok(KIND_STRING, sc_start, span_to(cur_pos), sc_line, sc_col);
                    sc_mode = SC_IDLE;
                end
            SC_INT:
                if (c == CH_DOT) sc_mode = SC_FRAC;
                else if (!digit_ch(c))
                begin
                    flush_pending(cur_pos);
                    begin_token(c, nl);
                end
            SC_FRAC:
                if (!digit_ch(c))
                begin
                    flush_pending(cur_pos);
                    begin_token(c, nl);
                end
            SC_WORD:
                if (c == CH_UNDER || letter_ch(c) || digit_ch(c))
                    sc_win = {sc_win[WIN_BITS-9:0], c};
                else
                begin
                    flush_pending(cur_pos);
                    begin_token(c, nl);
                end
            SC_OPER:
            begin
                pk = KIND_NONE;
                if (c == CH_EQ)
                    pk = (sc_op == CH_LT) ? KIND_LE : (sc_op == CH_GT) ? KIND_GE : KIND_EQEQ;
                if (pk != KIND_NONE)
                begin
                    push_tok(pk, sc_start, 2, sc_line, sc_col);
                    sc_mode = SC_IDLE;
                end
                else
                begin
                    flush_pending(cur_pos);
                    begin_token(c, nl);
                end
            end
            default: begin_token(c, nl);
        endcase
        if (fin) flush_pending({44'd0, cur_pos} + 64'd1);
        cur_pos = inc_pos(cur_pos);
        if (nl)
        begin
            cur_line = inc_pos(cur_line);
            cur_col = 0;
        end
        else cur_col = inc_pos(cur_col);
        if (fin)
        begin
            push_tok(KIND_END, cur_pos, 0, cur_line, cur_col);
            clear_scanner();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = 1;
            #5 clk = 0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: stall pattern of its own
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 400 < 120) out_ready <= 1;
            else if (stall_phase % 400 < 200) out_ready <= ($urandom_range(0, 3) != 0);
            else out_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // checker
    always @(posedge clk)
    begin
        tok_exp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (token_queue.size() == 0)
                report("unexpected kind", token_kind, 0);
            else
            begin
                want = token_queue.pop_front();
                if (token_kind != want.kind) report("kind", token_kind, want.kind);
                if (start_offset != want.start) report("start", start_offset, want.start);
                if (text_length != want.len) report("length", text_length, want.len);
                if (line_number != want.line) report("line", line_number, want.line);
                if (column_number != want.col) report("column", column_number, want.col);
                if (run_last != want.last) report("run_last", run_last, want.last);
            end
        end
    end

    int burst_left;

    // send one request, honoring the burst/gap pattern
    task automatic send_byte(logic [7:0] c, logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1;
        char_in <= c;
        is_last <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        scan_byte(c, fin);
        burst_left--;
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic send_text(string s, logic fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_at_end && i == s.len() - 1);
    endtask

    row_t rows[$];
    int sent;

    task automatic add_row(logic [7:0] c, logic fin, logic he, kind_t k, pos_t s);
        row_t r;
        r.ch = c;
        r.fin = fin;
        r.has_exp = he;
        r.kind = k;
        r.start = s;
        rows.push_back(r);
    endtask

    initial
    begin
        logic [7:0] frag[$];
        int sel;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        rst_n = 0;
        in_valid = 0;
        char_in = 0;
        is_last = 0;
        clear_scanner();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every operator kind but a lone '>', string quoting, end handling
        add_row(8'h00, 0, 0, KIND_NONE, 0);
        add_row(8'hFF, 0, 0, KIND_NONE, 0);
        add_row("(", 0, 1, 5'd7, 2);
        add_row("<", 0, 0, KIND_NONE, 0);
        add_row("=", 0, 1, KIND_LE, 3);
        add_row(">", 0, 0, KIND_NONE, 0);
        add_row("=", 0, 1, KIND_GE, 5);
        add_row("=", 0, 0, KIND_NONE, 0);
        add_row("=", 0, 1, KIND_EQEQ, 7);
        add_row(".", 0, 0, KIND_NONE, 0);
        add_row(".", 0, 0, KIND_NONE, 0);
        add_row(".", 0, 0, KIND_NONE, 0);
        add_row("'", 0, 0, KIND_NONE, 0);
        add_row(8'h0A, 0, 0, KIND_NONE, 0);
        add_row("\"", 0, 0, KIND_NONE, 0);
        add_row("'", 0, 0, KIND_NONE, 0);
        add_row("#", 0, 0, KIND_NONE, 0);
        add_row("x", 1, 0, KIND_NONE, 0);
        add_row("\"", 0, 0, KIND_NONE, 0);
        add_row("a", 1, 0, KIND_NONE, 0);
        add_row("=", 1, 0, KIND_NONE, 0);
        foreach (rows[i])
        begin
            int first_n;
            send_byte(rows[i].ch, rows[i].fin);
            if (rows[i].has_exp)
            begin
                if (step_toks.size() == 0)
                    report("row token count", 0, 1);
                else
                begin
                    // this byte's tokens sit at the tail of the queue
                    first_n = token_queue.size() - step_toks.size();
                    token_queue[first_n].kind = rows[i].kind;
                    token_queue[first_n].start = rows[i].start;
                end
            end
        end
        send_text("var if fn return ret _x9 ){}+-*/:<>=7.5.1 ", 1);

        // hold off until every expected token is out
        in_valid <= 0;
        while (token_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        // random source text, mostly well formed
        sent = 0;
        while (sent < 480)
        begin
            sel = $urandom_range(0, 19);
            case (sel)
                0, 1, 2: frag = '{pick("vifr"), pick("aenft"), pick("rnu_9")};
                3: frag = '{"r", "e", "t", "u", "r", "n"};
                4: frag = '{"v", "a", "r"};
                5, 6: frag = '{pick("0123456789."), pick("0123456789."), pick("09.")};
                7: frag = '{pick("\"'"), pick("ab\n'\" "), pick("\"'x")};
                8: frag = '{"#", pick("ab ("), CH_NL};
                9, 10: frag = '{pick("(){}+-*/:<>="), pick("=<>= ")};
                11, 12: frag = '{pick(" \t\n\r")};
                13: frag = '{pick("ifn"), pick("fn")};
                default: frag = '{8'($urandom_range(0, 255))};
            endcase
            for (int i = 0; i < frag.size(); i++)
            begin
                send_byte(frag[i], $urandom_range(0, 60) == 0);
                sent++;
            end
        end
        send_byte(" ", 1);
        in_valid <= 0;

        while (token_queue.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && token_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
sv/srclex_pkg.sv
sv/srclex_scan.sv
sv/srclex_queue.sv
sv/srclex_emit.sv
sv/source_lexer_core.sv
sv/srclex_checker.sv
tb/tb.sv
